FILE: hdl/nlc_pkg.sv
package nlc_pkg;

  // Character codes used by the grammar
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam int unsigned ACC_W  = 33;
  localparam int unsigned PROD_W = 37;
  localparam logic [ACC_W-1:0] MAG_CAP  = 33'h1_0000_0000;
  localparam logic [ACC_W-1:0] NEG_LIM  = 33'h0_8000_0000;
  localparam logic [ACC_W-1:0] POS_LIM  = 33'h0_7FFF_FFFF;
  localparam logic [31:0]      VAL_MIN  = 32'h8000_0000;
  localparam logic [31:0]      VAL_MAX  = 32'h7FFF_FFFF;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_INT     = 2'd1,
    KIND_HEX     = 2'd2,
    KIND_FLOAT   = 2'd3
  } kind_t;

  // Grammar position
  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ZERO = 4'd1,
    PH_INT  = 4'd2,
    PH_FRAC = 4'd3,
    PH_EXP0 = 4'd4,
    PH_EXP  = 4'd5,
    PH_HEX0 = 4'd6,
    PH_HEX  = 4'd7
  } phase_t;

  // Accumulator update selected by the sequencer
  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_DEC  = 2'd1,
    ACC_HEX  = 2'd2
  } acc_op_t;

  // Pre-decoded character, carried through the queue
  typedef struct packed {
    logic       first;
    logic       is_term;
    logic       is_dec;
    logic       is_hex;
    logic       is_zero;
    logic       is_minus;
    logic       is_plus;
    logic       is_dot;
    logic       is_e;
    logic       is_x;
    logic [3:0] digit;
  } item_t;

endpackage

FILE: hdl/number_literal_classifier_core.sv
// Number literal classifier: one token character per transfer, one result per character.
// The result is registered twice on its way out: queue write, then output register.
// Throughput: 1 character per cycle while neither in_stall nor out_stall holds the flow; the
// per-character state update in the back end is a combinational shift-add and compare.
// Reset (rst_n low, synchronous): queue emptied, output invalid, grammar state idle.
module number_literal_classifier_core #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_done_res,
  output logic [1:0]  out_kind,
  output logic [31:0] out_value,
  output logic        out_saturated
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_not_empty;
  nlc_pkg::item_t push_item;
  nlc_pkg::item_t pop_item;

  // Accept and decode
  nlc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch    (in_ch),
    .in_first (in_first),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // Decoupling queue
  nlc_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  // Grammar sequencer, accumulator and result register
  nlc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_not_empty),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_done_res  (out_done_res),
    .out_kind      (out_kind),
    .out_value     (out_value),
    .out_saturated (out_saturated)
  );

endmodule

FILE: hdl/nlc_front.sv
module nlc_front (
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_ch,
  input  logic           in_first,
  input  logic           q_full,
  output logic           q_push,
  output nlc_pkg::item_t q_item
);

  // Stall while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Character decode
  always_comb begin
    q_item          = '0;
    q_item.first    = in_first;
    q_item.is_term  = (in_ch == nlc_pkg::CH_NUL) || (in_ch == nlc_pkg::CH_SPACE);
    q_item.is_dec   = in_ch inside {[nlc_pkg::CH_0:nlc_pkg::CH_9]};
    q_item.is_zero  = (in_ch == nlc_pkg::CH_0);
    q_item.is_minus = (in_ch == nlc_pkg::CH_MINUS);
    q_item.is_plus  = (in_ch == nlc_pkg::CH_PLUS);
    q_item.is_dot   = (in_ch == nlc_pkg::CH_DOT);
    q_item.is_e     = (in_ch == nlc_pkg::CH_LE);
    q_item.is_x     = (in_ch == nlc_pkg::CH_LX) || (in_ch == nlc_pkg::CH_UX);
    // hex digit value; decimal digits share the low nibble
    if (in_ch inside {[nlc_pkg::CH_0:nlc_pkg::CH_9]}) begin
      q_item.is_hex = 1'b1;
      q_item.digit  = in_ch[3:0];
    end else if (in_ch inside {[nlc_pkg::CH_LA:nlc_pkg::CH_LF],
                               [nlc_pkg::CH_UA:nlc_pkg::CH_UF]}) begin
      q_item.is_hex = 1'b1;
      q_item.digit  = 4'(in_ch[2:0] + 3'd1) + 4'd8;
    end
  end

endmodule

FILE: hdl/nlc_fifo.sv
module nlc_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nlc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output nlc_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  nlc_pkg::item_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue occupancy out of range");
`endif

endmodule

FILE: hdl/nlc_back.sv
module nlc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  nlc_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_done_res,
  output logic [1:0]     out_kind,
  output logic [31:0]    out_value,
  output logic           out_saturated
);

  localparam int unsigned AW = nlc_pkg::ACC_W;
  localparam int unsigned PW = nlc_pkg::PROD_W;

  nlc_pkg::phase_t  phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [AW-1:0]    acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;

  logic             out_valid_r;
  logic             out_done_r, out_done_nxt;
  nlc_pkg::kind_t   out_kind_r, out_kind_nxt;
  logic [31:0]      out_value_r, out_value_nxt;
  logic             out_sat_r, out_sat_nxt;

  logic             take;
  nlc_pkg::phase_t  eff_phase;
  logic             int_mode;
  nlc_pkg::acc_op_t acc_op;
  logic             fin;
  nlc_pkg::kind_t   fin_kind;
  logic [AW-1:0]    acc_base;
  logic             neg_base;
  logic             ovf_base;
  logic [PW-1:0]    prod;

  // Take from the queue when the output register is free or draining
  assign take  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = take;

  // A new token starts from the integer position
  assign eff_phase = q_item.first ? nlc_pkg::PH_INT : phase_r;
  assign int_mode  = (eff_phase == nlc_pkg::PH_INT) ||
                     ((eff_phase == nlc_pkg::PH_ZERO) && !q_item.is_x);

  // Next state and action selection
  always_comb begin
    phase_nxt = phase_r;
    acc_op    = nlc_pkg::ACC_NONE;
    fin       = 1'b0;
    fin_kind  = nlc_pkg::KIND_INVALID;
    if (q_item.first && q_item.is_minus) begin
      phase_nxt = nlc_pkg::PH_INT;
    end else if (q_item.first && q_item.is_zero) begin
      phase_nxt = nlc_pkg::PH_ZERO;
    end else if (int_mode) begin
      phase_nxt = nlc_pkg::PH_INT;
      if (q_item.is_dec) begin
        acc_op = nlc_pkg::ACC_DEC;
      end else if (q_item.is_dot) begin
        phase_nxt = nlc_pkg::PH_FRAC;
      end else if (q_item.is_e) begin
        phase_nxt = nlc_pkg::PH_EXP0;
      end else begin
        fin      = 1'b1;
        fin_kind = q_item.is_term ? nlc_pkg::KIND_INT : nlc_pkg::KIND_INVALID;
      end
    end else begin
      case (eff_phase)
        nlc_pkg::PH_ZERO: begin
          phase_nxt = nlc_pkg::PH_HEX0;
        end
        nlc_pkg::PH_FRAC: begin
          if (q_item.is_dec) begin
            phase_nxt = nlc_pkg::PH_FRAC;
          end else if (q_item.is_e) begin
            phase_nxt = nlc_pkg::PH_EXP0;
          end else begin
            fin      = 1'b1;
            fin_kind = q_item.is_term ? nlc_pkg::KIND_FLOAT : nlc_pkg::KIND_INVALID;
          end
        end
        nlc_pkg::PH_EXP0: begin
          if (q_item.is_plus || q_item.is_minus || q_item.is_dec) begin
            phase_nxt = nlc_pkg::PH_EXP;
          end else begin
            fin      = 1'b1;
            fin_kind = q_item.is_term ? nlc_pkg::KIND_FLOAT : nlc_pkg::KIND_INVALID;
          end
        end
        nlc_pkg::PH_EXP: begin
          if (!q_item.is_dec) begin
            fin      = 1'b1;
            fin_kind = q_item.is_term ? nlc_pkg::KIND_FLOAT : nlc_pkg::KIND_INVALID;
          end
        end
        nlc_pkg::PH_HEX0: begin
          if (q_item.is_hex) begin
            acc_op    = nlc_pkg::ACC_HEX;
            phase_nxt = nlc_pkg::PH_HEX;
          end else begin
            fin = 1'b1;
          end
        end
        nlc_pkg::PH_HEX: begin
          if (q_item.is_hex) begin
            acc_op = nlc_pkg::ACC_HEX;
          end else begin
            fin      = 1'b1;
            fin_kind = q_item.is_term ? nlc_pkg::KIND_HEX : nlc_pkg::KIND_INVALID;
          end
        end
        default: begin
          phase_nxt = nlc_pkg::PH_IDLE;
        end
      endcase
    end
    if (fin) begin
      phase_nxt = nlc_pkg::PH_IDLE;
    end
  end

  // Token state as seen by this character (cleared on restart)
  assign acc_base = q_item.first ? '0 : acc_r;
  assign neg_base = q_item.first ? q_item.is_minus : neg_r;
  assign ovf_base = q_item.first ? 1'b0 : ovf_r;

  // Shift-add multiply by the radix, plus the digit
  always_comb begin
    case (acc_op)
      nlc_pkg::ACC_DEC: prod = (PW'(acc_base) << 3) + (PW'(acc_base) << 1) + PW'(q_item.digit);
      nlc_pkg::ACC_HEX: prod = (PW'(acc_base) << 4) + PW'(q_item.digit);
      default:          prod = PW'(acc_base);
    endcase
  end

  // Datapath and result outputs
  always_comb begin
    neg_nxt       = neg_base;
    acc_nxt       = acc_base;
    ovf_nxt       = ovf_base;
    out_done_nxt  = fin;
    out_kind_nxt  = fin ? fin_kind : nlc_pkg::KIND_INVALID;
    out_value_nxt = '0;
    out_sat_nxt   = 1'b0;
    if (acc_op != nlc_pkg::ACC_NONE) begin
      if (prod > PW'(nlc_pkg::MAG_CAP)) begin
        acc_nxt = nlc_pkg::MAG_CAP;
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = prod[AW-1:0];
      end
    end
    // Signed conversion with clamping
    if (fin && (fin_kind == nlc_pkg::KIND_INT || fin_kind == nlc_pkg::KIND_HEX)) begin
      if (neg_base) begin
        if (ovf_base || acc_base > nlc_pkg::NEG_LIM) begin
          out_sat_nxt   = 1'b1;
          out_value_nxt = nlc_pkg::VAL_MIN;
        end else begin
          out_value_nxt = 32'd0 - acc_base[31:0];
        end
      end else begin
        if (ovf_base || acc_base > nlc_pkg::POS_LIM) begin
          out_sat_nxt   = 1'b1;
          out_value_nxt = nlc_pkg::VAL_MAX;
        end else begin
          out_value_nxt = acc_base[31:0];
        end
      end
    end
  end

  // Token state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nlc_pkg::PH_IDLE;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_done_r  <= out_done_nxt;
      out_kind_r  <= out_kind_nxt;
      out_value_r <= out_value_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_done_res  = out_done_r;
  assign out_kind      = out_kind_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

`ifndef SYNTHESIS
  a_acc_capped: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (acc_r == nlc_pkg::MAG_CAP))
    else $error("overflow flag set without capped magnitude");

  a_undecided_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_done_r) |->
      (out_kind_r == nlc_pkg::KIND_INVALID && out_value_r == 32'd0 && !out_sat_r))
    else $error("undecided result carries payload");

  a_sat_only_int: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_kind_r == nlc_pkg::KIND_INT || out_kind_r == nlc_pkg::KIND_HEX))
    else $error("saturation flagged on non-integer kind");

  a_finish_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && fin) |=> (phase_r == nlc_pkg::PH_IDLE))
    else $error("decided token did not return to idle");
`endif

endmodule

FILE: sim/number_literal_classifier_core_tb.sv
`timescale 1ns / 1ps

module number_literal_classifier_core_tb;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned TAIL_CYCLES = 8;

  typedef enum int {
    IDLE_NONE,
    IDLE_LIGHT,
    IDLE_HEAVY
  } idle_mode_t;

  // One classifier output as seen on the result channel
  typedef struct {
    logic           done_res;
    nlc_pkg::kind_t kind;
    logic [31:0]    value;
    logic           saturated;
  } lit_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'h00;
  logic        in_first = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_done_res;
  logic [1:0]  out_kind;
  logic [31:0] out_value;
  logic        out_saturated;

  // Predicted token state
  nlc_pkg::phase_t tok_phase = nlc_pkg::PH_IDLE;
  logic            tok_neg = 1'b0;
  logic [32:0]     tok_mag = '0;
  logic            tok_ovf = 1'b0;

  lit_result_t predicted_results[$];
  int          mismatch_count = 0;
  int          char_count = 0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;
  idle_mode_t  tx_idle_mode = IDLE_NONE;
  idle_mode_t  rx_idle_mode = IDLE_NONE;

  number_literal_classifier_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_ch         (in_ch),
    .in_first      (in_first),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_done_res  (out_done_res),
    .out_kind      (out_kind),
    .out_value     (out_value),
    .out_saturated (out_saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  function automatic logic is_term(logic [7:0] ch);
    return ch == nlc_pkg::CH_NUL || ch == nlc_pkg::CH_SPACE;
  endfunction

  function automatic logic is_dec(logic [7:0] ch);
    return ch >= nlc_pkg::CH_0 && ch <= nlc_pkg::CH_9;
  endfunction

  // -1 when not a hex digit
  function automatic int hex_digit(logic [7:0] ch);
    if (is_dec(ch)) return int'(ch - nlc_pkg::CH_0);
    if (ch >= nlc_pkg::CH_LA && ch <= nlc_pkg::CH_LF) return int'(ch - nlc_pkg::CH_LA) + 10;
    if (ch >= nlc_pkg::CH_UA && ch <= nlc_pkg::CH_UF) return int'(ch - nlc_pkg::CH_UA) + 10;
    return -1;
  endfunction

  // Magnitude grows until it is pinned at 2^32
  function automatic void add_digit(int unsigned base, int unsigned digit);
    logic [63:0] n;
    n = 64'(tok_mag) * base + digit;
    if (n > 64'(nlc_pkg::MAG_CAP)) begin
      n = 64'(nlc_pkg::MAG_CAP);
      tok_ovf = 1'b1;
    end
    tok_mag = n[32:0];
  endfunction

  function automatic lit_result_t close_token(nlc_pkg::kind_t k);
    lit_result_t r;
    r.done_res = 1'b1;
    r.kind = k;
    r.value = '0;
    r.saturated = 1'b0;
    if (k == nlc_pkg::KIND_INT || k == nlc_pkg::KIND_HEX) begin
      if (tok_neg) begin
        if (tok_ovf || tok_mag > nlc_pkg::NEG_LIM) begin
          r.saturated = 1'b1;
          r.value = nlc_pkg::VAL_MIN;
        end else begin
          r.value = 32'd0 - tok_mag[31:0];
        end
      end else begin
        if (tok_ovf || tok_mag > nlc_pkg::POS_LIM) begin
          r.saturated = 1'b1;
          r.value = nlc_pkg::VAL_MAX;
        end else begin
          r.value = tok_mag[31:0];
        end
      end
    end
    tok_phase = nlc_pkg::PH_IDLE;
    return r;
  endfunction

  function automatic lit_result_t classify_char(logic [7:0] ch, logic first);
    lit_result_t r;
    int hv;
    r.done_res = 1'b0;
    r.kind = nlc_pkg::KIND_INVALID;
    r.value = '0;
    r.saturated = 1'b0;

    // start of a token drops whatever was in progress
    if (first) begin
      tok_neg = 1'b0;
      tok_mag = '0;
      tok_ovf = 1'b0;
      if (ch == nlc_pkg::CH_MINUS) begin
        tok_neg = 1'b1;
        tok_phase = nlc_pkg::PH_INT;
        return r;
      end
      if (ch == nlc_pkg::CH_0) begin
        tok_phase = nlc_pkg::PH_ZERO;
        return r;
      end
      tok_phase = nlc_pkg::PH_INT;
    end

    // a leading zero opens a hex prefix or is just part of the int
    if (tok_phase == nlc_pkg::PH_ZERO) begin
      if (ch == nlc_pkg::CH_LX || ch == nlc_pkg::CH_UX) begin
        tok_phase = nlc_pkg::PH_HEX0;
        return r;
      end
      tok_phase = nlc_pkg::PH_INT;
    end

    hv = hex_digit(ch);
    case (tok_phase)
      nlc_pkg::PH_INT: begin
        if (is_dec(ch)) add_digit(10, int'(ch - nlc_pkg::CH_0));
        else if (ch == nlc_pkg::CH_DOT) tok_phase = nlc_pkg::PH_FRAC;
        else if (ch == nlc_pkg::CH_LE) tok_phase = nlc_pkg::PH_EXP0;
        else if (is_term(ch)) r = close_token(nlc_pkg::KIND_INT);
        else r = close_token(nlc_pkg::KIND_INVALID);
      end
      nlc_pkg::PH_FRAC: begin
        if (ch == nlc_pkg::CH_LE) tok_phase = nlc_pkg::PH_EXP0;
        else if (is_term(ch)) r = close_token(nlc_pkg::KIND_FLOAT);
        else if (!is_dec(ch)) r = close_token(nlc_pkg::KIND_INVALID);
      end
      nlc_pkg::PH_EXP0: begin
        if (ch == nlc_pkg::CH_PLUS || ch == nlc_pkg::CH_MINUS || is_dec(ch))
          tok_phase = nlc_pkg::PH_EXP;
        else if (is_term(ch)) r = close_token(nlc_pkg::KIND_FLOAT);
        else r = close_token(nlc_pkg::KIND_INVALID);
      end
      nlc_pkg::PH_EXP: begin
        if (is_term(ch)) r = close_token(nlc_pkg::KIND_FLOAT);
        else if (!is_dec(ch)) r = close_token(nlc_pkg::KIND_INVALID);
      end
      nlc_pkg::PH_HEX0: begin
        if (hv >= 0) begin
          add_digit(16, hv);
          tok_phase = nlc_pkg::PH_HEX;
        end else begin
          r = close_token(nlc_pkg::KIND_INVALID);
        end
      end
      nlc_pkg::PH_HEX: begin
        if (hv >= 0) add_digit(16, hv);
        else if (is_term(ch)) r = close_token(nlc_pkg::KIND_HEX);
        else r = close_token(nlc_pkg::KIND_INVALID);
      end
      default: tok_phase = nlc_pkg::PH_IDLE;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle draws shared by both channels
  // ---------------------------------------------------------------------------
  function automatic int draw_wait(idle_mode_t m);
    case (m)
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
      IDLE_HEAVY: return int'($urandom_range(0, 17));
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall and compare against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    lit_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result transfer with no prediction pending");
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_done_res !== want.done_res) begin
            $error("done_res: expected %0d, actual %0d", want.done_res, out_done_res);
            mismatch_count++;
          end
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_kind);
            mismatch_count++;
          end
          if (out_value !== want.value) begin
            $error("value: expected %0d, actual %0d", $signed(want.value),
                   $signed(out_value));
            mismatch_count++;
          end
          if (out_saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, out_saturated);
            mismatch_count++;
          end
        end
        stall_left = draw_wait(rx_idle_mode);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // One character transfer; valid stays up afterwards until the next call or a drain
  task automatic send_char(logic [7:0] ch, logic first);
    int gap;
    lit_result_t pred;
    gap = draw_wait(tx_idle_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= ch;
    in_first <= first;
    do @(posedge clk); while (in_stall);
    pred = classify_char(ch, first);
    predicted_results.insert(predicted_results.size(), pred);
    char_count++;
  endtask

  // Token body followed by an optional closing character
  task automatic send_literal(string body, logic [7:0] tail, bit has_tail);
    for (int i = 0; i < body.len(); i++) send_char(body[i], i == 0);
    if (has_tail) send_char(tail, body.len() == 0);
  endtask

  // Sender holds off until every predicted result has been seen
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    wait (predicted_results.size() == 0);
    @(posedge clk);
  endtask

  // Magnitudes, partly clustered at the saturation limits
  function automatic longint unsigned pick_magnitude();
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, 999);
      1: return 64'd2147483648 + $urandom_range(0, 6) - 3;
      2: return 64'd4294967296 + $urandom_range(0, 6) - 3;
      3: return $urandom;
      4: return {$urandom, $urandom} >> $urandom_range(0, 63);
      5: return 64'd0;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  task automatic send_random_literal();
    string body;
    string digits;
    longint unsigned mag;
    logic [7:0] tail;
    bit has_tail;
    int sel;
    digits = "0123456789";
    body = "";
    case ($urandom_range(0, 8))
      // decimal int
      0, 1, 2: begin
        mag = pick_magnitude();
        body = $sformatf("%0d", mag);
        if ($urandom_range(0, 7) == 0) body = {"0", body};
        if ($urandom_range(0, 1) == 1) body = {"-", body};
      end
      // hex, mixed case digits and prefix
      3, 4: begin
        mag = pick_magnitude();
        body = $sformatf("%0h", mag);
        if ($urandom_range(0, 5) == 0) body = {"00", body};
        if ($urandom_range(0, 9) == 0) body = "";
        for (int i = 0; i < body.len(); i++) begin
          if (body[i] >= nlc_pkg::CH_LA && body[i] <= nlc_pkg::CH_LF &&
              $urandom_range(0, 1) == 1)
            body[i] = body[i] - 8'h20;
        end
        if ($urandom_range(0, 1) == 1) body = {"0x", body};
        else body = {"0X", body};
        if ($urandom_range(0, 11) == 0) body = {"-", body};
      end
      // float: every part optional
      5, 6: begin
        if ($urandom_range(0, 3) == 0) body = "-";
        repeat ($urandom_range(0, 3)) begin
          sel = $urandom_range(0, 9);
          body = {body, digits.substr(sel, sel)};
        end
        if ($urandom_range(0, 2) != 0) begin
          body = {body, "."};
          repeat ($urandom_range(0, 3)) begin
            sel = $urandom_range(0, 9);
            body = {body, digits.substr(sel, sel)};
          end
        end
        if ($urandom_range(0, 1) == 1) begin
          if ($urandom_range(0, 5) == 0) body = {body, "E"};
          else body = {body, "e"};
          sel = $urandom_range(0, 2);
          if (sel == 1) body = {body, "+"};
          if (sel == 2) body = {body, "-"};
          repeat ($urandom_range(0, 3)) begin
            sel = $urandom_range(0, 9);
            body = {body, digits.substr(sel, sel)};
          end
        end
      end
      // raw bytes, also while idle
      7: begin
        repeat ($urandom_range(1, 4))
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        return;
      end
      // degenerate tokens
      default: begin
        case ($urandom_range(0, 5))
          0: body = "";
          1: body = "-";
          2: body = ".";
          3: body = "e";
          4: body = "0";
          default: body = "-0";
        endcase
      end
    endcase

    // closing character: terminator, junk, or none so the next token restarts
    sel = $urandom_range(0, 15);
    has_tail = 1'b1;
    if (sel < 6) tail = nlc_pkg::CH_SPACE;
    else if (sel < 11) tail = nlc_pkg::CH_NUL;
    else if (sel < 14) tail = 8'($urandom_range(0, 255));
    else begin
      tail = nlc_pkg::CH_NUL;
      has_tail = 1'b0;
    end
    send_literal(body, tail, has_tail);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_special_cases();
    tx_idle_mode = IDLE_NONE;
    rx_idle_mode = IDLE_NONE;
    send_char(8'h7A, 1'b0);                      // idle, not a start: ignored
    send_literal("", nlc_pkg::CH_SPACE, 1'b1);   // empty token
    send_literal("-", nlc_pkg::CH_NUL, 1'b1);    // lone minus
    send_literal(".", nlc_pkg::CH_SPACE, 1'b1);  // lone dot
    send_literal("e", nlc_pkg::CH_SPACE, 1'b1);  // bare exponent
    send_literal("-0x", nlc_pkg::CH_SPACE, 1'b0);// minus before hex prefix
    send_literal("0x", nlc_pkg::CH_SPACE, 1'b1); // prefix with no digit
    send_literal("1E", nlc_pkg::CH_SPACE, 1'b0); // uppercase exponent
    send_literal("12", nlc_pkg::CH_NUL, 1'b0);   // abandoned by a restart
    send_literal("9", nlc_pkg::CH_NUL, 1'b1);
    send_literal("0xF", nlc_pkg::CH_SPACE, 1'b1);
    send_char(8'hFF, 1'b1);                      // top byte value
    hold_until_drained();
  endtask

  task automatic test_random_literals(int n_chars, idle_mode_t tx_mode, idle_mode_t rx_mode);
    int stop_at;
    tx_idle_mode = tx_mode;
    rx_idle_mode = rx_mode;
    stop_at = char_count + n_chars;
    while (char_count < stop_at) send_random_literal();
    hold_until_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_random_literals(400, IDLE_LIGHT, IDLE_LIGHT);
    test_random_literals(400, IDLE_NONE, IDLE_NONE);
    test_random_literals(400, IDLE_HEAVY, IDLE_NONE);
    test_random_literals(400, IDLE_NONE, IDLE_HEAVY);
    test_random_literals(400, IDLE_HEAVY, IDLE_HEAVY);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/nlc_pkg.sv
hdl/nlc_front.sv
hdl/nlc_fifo.sv
hdl/nlc_back.sv
hdl/number_literal_classifier_core.sv
sim/number_literal_classifier_core_tb.sv
